### src/slep_pkg.sv
// shared types and constants for the source line execution profiler
// no dependencies; imported by every other file of the block except slep_ram
package slep_pkg;

    localparam int FILE_ID_BITS  = 32;
    localparam int LINE_BITS     = 10;
    localparam int OUT_BITS      = 32;
    localparam int S_TDATA_BITS  = 48;
    localparam int M_TDATA_BITS  = 64;
    localparam int LINE_CMP_BITS = 17;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_COUNT,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      entered;
        logic      found;
        logic      dropped;
    } cmd_ctl_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_ACCESS
    } back_state_t;

endpackage

### src/slep_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module slep_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/slep_front.sv
// front end: accepts transfers, tracks file slots and the current line,
// and turns each item into a counter command; uses slep_pkg
module slep_front #(
    parameter int MAX_FILES = 8,
    parameter int MAX_LINES = 1024,
    parameter int AW        = 13
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              op,
    input  logic [slep_pkg::FILE_ID_BITS-1:0] file_id,
    input  logic [slep_pkg::LINE_BITS-1:0]    line,
    input  logic                              busy,
    input  logic                              q_ready,
    output logic                              q_push,
    output slep_pkg::cmd_ctl_t                q_ctl,
    output logic [AW-1:0]                     q_addr
);
    import slep_pkg::*;

    localparam int SW  = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
    localparam int FUW = $clog2(MAX_FILES + 1);

    logic [FILE_ID_BITS-1:0] fid_reg [MAX_FILES];
    logic [FUW-1:0]          used_reg, used_next;
    logic [SW-1:0]           cur_slot_reg, cur_slot_next;
    logic                    cur_known_reg, cur_known_next;
    logic [LINE_BITS-1:0]    prev_line_reg, prev_line_next;
    logic                    prev_known_reg, prev_known_next;

    logic [MAX_FILES-1:0] hit;
    logic [SW-1:0]        hit_slot;
    logic [SW-1:0]        tslot;
    logic [SW-1:0]        acc_slot;
    logic                 found;
    logic                 full;
    logic                 line_ok;
    logic                 same;
    logic                 prev_known_eff;
    logic                 insert;
    logic                 accept;

    // parallel match against the taken slots; identifiers are unique
    always_comb begin
        for (int i = 0; i < MAX_FILES; i++) begin
            hit[i] = (FUW'(i) < used_reg) && (fid_reg[i] == file_id);
        end
        hit_slot = '0;
        for (int i = MAX_FILES - 1; i >= 0; i--) begin
            if (hit[i]) begin
                hit_slot = SW'(i);
            end
        end
    end

    assign found    = |hit;
    assign full     = (used_reg == FUW'(MAX_FILES));
    assign line_ok  = (LINE_CMP_BITS'(line) < LINE_CMP_BITS'(MAX_LINES));
    assign tslot    = found ? hit_slot : used_reg[SW-1:0];
    assign same     = cur_known_reg && found && (hit_slot == cur_slot_reg);
    assign acc_slot = (op == OP_READ) ? hit_slot : tslot;
    assign q_addr   = AW'(acc_slot) * AW'(MAX_LINES) + AW'(line);
    assign in_ready = !busy && q_ready;
    assign accept   = in_valid && in_ready;

    always_comb begin
        used_next       = used_reg;
        cur_slot_next   = cur_slot_reg;
        cur_known_next  = cur_known_reg;
        prev_line_next  = prev_line_reg;
        prev_known_next = prev_known_reg;
        prev_known_eff  = prev_known_reg;
        insert          = 1'b0;
        q_push          = 1'b0;
        q_ctl           = '{kind: CMD_NONE, entered: 1'b0, found: 1'b0, dropped: 1'b0};
        if (accept) begin
            q_push = 1'b1;
            if (op == OP_READ) begin
                if (found) begin
                    q_ctl.found = 1'b1;
                    if (line_ok) begin
                        q_ctl.kind = CMD_READ;
                    end else begin
                        q_ctl.dropped = 1'b1;
                    end
                end
            end else if (file_id != '0) begin
                if (!found && full) begin
                    cur_known_next  = 1'b0;
                    prev_known_next = 1'b0;
                    q_ctl.dropped   = 1'b1;
                end else begin
                    if (!found) begin
                        insert    = 1'b1;
                        used_next = used_reg + FUW'(1);
                    end
                    // switching file restarts the line tracking
                    if (!same) begin
                        cur_slot_next  = tslot;
                        cur_known_next = 1'b1;
                        prev_known_eff = 1'b0;
                    end
                    q_ctl.entered   = !prev_known_eff || (line != prev_line_reg);
                    q_ctl.found     = 1'b1;
                    prev_line_next  = line;
                    prev_known_next = 1'b1;
                    if (line_ok) begin
                        q_ctl.kind = CMD_COUNT;
                    end else begin
                        q_ctl.dropped = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg       <= '0;
            cur_slot_reg   <= '0;
            cur_known_reg  <= 1'b0;
            prev_line_reg  <= '0;
            prev_known_reg <= 1'b0;
        end else begin
            used_reg       <= used_next;
            cur_slot_reg   <= cur_slot_next;
            cur_known_reg  <= cur_known_next;
            prev_line_reg  <= prev_line_next;
            prev_known_reg <= prev_known_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (insert) begin
            fid_reg[used_reg[SW-1:0]] <= file_id;
        end
    end

endmodule

### src/slep_queue.sv
// short command queue between front and back end
// uses slep_pkg for the depth
module slep_queue #(
    parameter int WIDTH = 17
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             pop_valid
);
    import slep_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] ent_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = ent_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/slep_back.sv
// back end: clears the counter ram after reset, then reads counter pairs,
// writes back incremented pairs for count commands and drives the result register; uses slep_pkg, slep_ram
module slep_back #(
    parameter int MAX_FILES  = 8,
    parameter int MAX_LINES  = 1024,
    parameter int COUNT_BITS = 32,
    parameter int AW         = 13
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  slep_pkg::cmd_ctl_t            q_ctl,
    input  logic [AW-1:0]                 q_addr,
    output logic                          clearing,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [slep_pkg::OUT_BITS-1:0] out_entries,
    output logic [slep_pkg::OUT_BITS-1:0] out_instructions,
    output logic                          out_found,
    output logic                          out_dropped
);
    import slep_pkg::*;

    localparam int DEPTH = MAX_FILES * MAX_LINES;
    localparam int XW    = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS + 1;

    function automatic logic [OUT_BITS-1:0] clip_out(input logic [COUNT_BITS-1:0] v);
        logic [XW-1:0] w;
        w = XW'(v);
        clip_out = (|w[XW-1:OUT_BITS]) ? '1 : w[OUT_BITS-1:0];
    endfunction

    back_state_t     state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    cmd_ctl_t        cur_ctl_reg, cur_ctl_next;
    logic [AW-1:0]   cur_addr_reg, cur_addr_next;

    logic                  valid_reg;
    logic [OUT_BITS-1:0]   ent_out_reg, ins_out_reg;
    logic                  found_reg, dropped_reg;
    logic                  load;
    logic [OUT_BITS-1:0]   ld_ent, ld_ins;
    logic                  ld_found, ld_dropped;
    logic                  out_free;

    logic                    ram_we, ram_re;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [2*COUNT_BITS-1:0] ram_wdata, ram_rdata;
    logic [COUNT_BITS-1:0]   ent_old, ins_old, ent_new, ins_new;
    logic                    is_count;

    slep_ram #(
        .WIDTH (2 * COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_cnt_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign ent_old  = ram_rdata[COUNT_BITS-1:0];
    assign ins_old  = ram_rdata[2*COUNT_BITS-1:COUNT_BITS];
    assign is_count = (cur_ctl_reg.kind == CMD_COUNT);
    // saturating increments
    assign ent_new  = (is_count && cur_ctl_reg.entered && !(&ent_old)) ?
                      ent_old + COUNT_BITS'(1) : ent_old;
    assign ins_new  = (is_count && !(&ins_old)) ? ins_old + COUNT_BITS'(1) : ins_old;
    assign out_free = !valid_reg || out_ready;
    assign clearing = (state_reg == BK_CLEAR);

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        cur_ctl_next  = cur_ctl_reg;
        cur_addr_next = cur_addr_reg;
        q_pop         = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = cur_addr_reg;
        ram_wdata     = {ins_new, ent_new};
        ram_re        = 1'b0;
        ram_raddr     = q_addr;
        load          = 1'b0;
        ld_ent        = '0;
        ld_ins        = '0;
        ld_found      = q_ctl.found;
        ld_dropped    = q_ctl.dropped;
        unique case (state_reg)
            BK_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (q_valid) begin
                    if (q_ctl.kind == CMD_NONE) begin
                        if (out_free) begin
                            q_pop = 1'b1;
                            load  = 1'b1;
                        end
                    end else begin
                        q_pop         = 1'b1;
                        ram_re        = 1'b1;
                        cur_ctl_next  = q_ctl;
                        cur_addr_next = q_addr;
                        state_next    = BK_ACCESS;
                    end
                end
            end
            BK_ACCESS: begin
                // read data stays in the ram output register while stalled
                if (out_free) begin
                    ram_we     = is_count;
                    load       = 1'b1;
                    ld_ent     = clip_out(ent_new);
                    ld_ins     = clip_out(ins_new);
                    ld_found   = cur_ctl_reg.found;
                    ld_dropped = cur_ctl_reg.dropped;
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_CLEAR;
            clr_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_ctl_reg  <= cur_ctl_next;
        cur_addr_reg <= cur_addr_next;
        if (load) begin
            ent_out_reg <= ld_ent;
            ins_out_reg <= ld_ins;
            found_reg   <= ld_found;
            dropped_reg <= ld_dropped;
        end
    end

    assign out_valid        = valid_reg;
    assign out_entries      = ent_out_reg;
    assign out_instructions = ins_out_reg;
    assign out_found        = found_reg;
    assign out_dropped      = dropped_reg;

endmodule

### src/source_line_execution_profiler.sv
// an item that touches counters goes through the command queue, a ram read in the
// back end access state and the result register to m_tvalid, any other item through the
// queue and the result register; the back end takes no new command until its access ends.
// reset: synchronous, active low; afterwards a clearing pass writes zero to all
// MAX_FILES * MAX_LINES counter pairs, one a cycle, with s_tready held low.
// uses slep_pkg, slep_front, slep_queue, slep_back, slep_ram
module source_line_execution_profiler #(
    parameter int MAX_FILES  = 8,
    parameter int MAX_LINES  = 1024,
    parameter int COUNT_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [slep_pkg::S_TDATA_BITS-1:0] s_tdata,  // file_id, line, zero pad
    input  logic [0:0]                        s_tuser,  // operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [slep_pkg::M_TDATA_BITS-1:0] m_tdata,  // entries, instructions
    output logic [1:0]                        m_tuser   // found, dropped
);
    import slep_pkg::*;

    localparam int AW = $clog2(MAX_FILES * MAX_LINES);
    localparam int QW = $bits(cmd_ctl_t) + AW;

    logic          q_push, q_ready, q_pop, q_valid, clearing;
    cmd_ctl_t      f_ctl, b_ctl;
    logic [AW-1:0] f_addr, b_addr;
    logic [QW-1:0] q_in, q_out;
    logic [OUT_BITS-1:0] entries, instructions;
    logic          found, dropped;

    slep_front #(
        .MAX_FILES (MAX_FILES),
        .MAX_LINES (MAX_LINES),
        .AW        (AW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .op       (s_tuser[0]),
        .file_id  (s_tdata[FILE_ID_BITS-1:0]),
        .line     (s_tdata[FILE_ID_BITS+LINE_BITS-1:FILE_ID_BITS]),
        .busy     (clearing),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_ctl    (f_ctl),
        .q_addr   (f_addr)
    );

    assign q_in = {f_ctl, f_addr};

    slep_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_data   (q_out),
        .pop_valid  (q_valid)
    );

    assign b_ctl  = cmd_ctl_t'(q_out[QW-1:AW]);
    assign b_addr = q_out[AW-1:0];

    slep_back #(
        .MAX_FILES  (MAX_FILES),
        .MAX_LINES  (MAX_LINES),
        .COUNT_BITS (COUNT_BITS),
        .AW         (AW)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_ctl            (b_ctl),
        .q_addr           (b_addr),
        .clearing         (clearing),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_entries      (entries),
        .out_instructions (instructions),
        .out_found        (found),
        .out_dropped      (dropped)
    );

    assign m_tdata = {instructions, entries};
    assign m_tuser = {dropped, found};

`ifndef NO_ASSERTIONS
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_tready)
        else $error("input accepted during counter clearing");

    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> q_ready)
        else $error("command queue overflow");

    a_zero_when_not_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (!found || dropped)) |-> (entries == '0 && instructions == '0))
        else $error("nonzero counters on a result without a counted line");

    a_entries_not_above_instr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (entries <= instructions))
        else $error("entry count exceeds instruction count");
`endif

endmodule

### tb/tb.sv
// self-checking testbench for source_line_execution_profiler: stream driver, result monitor
// and a line histogram predictor kept in step with every accepted count or read transfer
// depends on slep_pkg and the rtl under src
module tb;

    import slep_pkg::*;

    localparam int MAX_FILES  = 8;
    localparam int MAX_LINES  = 1024;
    localparam int COUNT_BITS = 32;
    localparam int N_RANDOM   = 1350;

    typedef struct packed {
        logic                    op;
        logic [FILE_ID_BITS-1:0] file_id;
        logic [LINE_BITS-1:0]    line;
    } trace_item_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] entries;
        logic [OUT_BITS-1:0] instructions;
        logic                found;
        logic                dropped;
    } line_counts_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata  = '0;  // file_id, line, zero pad
    logic [0:0]              s_tuser  = '0;  // operation
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;        // entries, instructions
    logic [1:0]              m_tuser;        // found, dropped

    // profiler shadow state
    logic [FILE_ID_BITS-1:0] file_slots [MAX_FILES];
    int                      files_used;
    int                      cur_slot;
    logic                    cur_slot_known;
    logic [LINE_BITS-1:0]    last_line;
    logic                    last_line_known;
    logic [COUNT_BITS-1:0]   entry_hist [MAX_FILES*MAX_LINES];
    logic [COUNT_BITS-1:0]   instr_hist [MAX_FILES*MAX_LINES];

    trace_item_t             pending_items [$];
    line_counts_t            expected_counts [$];
    int                      mismatches;
    int                      burst_left;
    int                      gap_left;
    int                      ready_mode;
    int                      ready_phase;

    source_line_execution_profiler #(
        .MAX_FILES (MAX_FILES),
        .MAX_LINES (MAX_LINES),
        .COUNT_BITS(COUNT_BITS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #4 aclk = ~aclk;

    function automatic int lookup_file(input logic [FILE_ID_BITS-1:0] id);
        for (int i = 0; i < files_used && i < MAX_FILES; i++) begin
            if (file_slots[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic line_counts_t profile_step(input trace_item_t it);
        line_counts_t r;
        int           slot;
        int           idx;
        logic         entered;
        r = '0;
        if (it.op == OP_READ) begin
            slot = lookup_file(it.file_id);
            if (slot < 0) begin
                return r;
            end
            r.found = 1'b1;
            if (int'(it.line) >= MAX_LINES) begin
                r.dropped = 1'b1;
                return r;
            end
            idx = slot * MAX_LINES + int'(it.line);
            r.entries      = entry_hist[idx];
            r.instructions = instr_hist[idx];
            return r;
        end
        // no file known: nothing moves
        if (it.file_id == '0) begin
            return r;
        end
        if (!cur_slot_known || cur_slot >= MAX_FILES || file_slots[cur_slot] != it.file_id) begin
            slot = lookup_file(it.file_id);
            if (slot < 0) begin
                if (files_used >= MAX_FILES) begin
                    // table full, tracking is lost until a known file returns
                    cur_slot_known  = 1'b0;
                    last_line_known = 1'b0;
                    r.dropped       = 1'b1;
                    return r;
                end
                slot = files_used;
                file_slots[files_used] = it.file_id;
                files_used++;
            end
            cur_slot        = slot;
            cur_slot_known  = 1'b1;
            last_line_known = 1'b0;
        end
        r.found = 1'b1;
        entered = !last_line_known || it.line != last_line;
        last_line       = it.line;
        last_line_known = 1'b1;
        if (int'(it.line) >= MAX_LINES) begin
            r.dropped = 1'b1;
            return r;
        end
        idx = cur_slot * MAX_LINES + int'(it.line);
        if (entered) begin
            entry_hist[idx] = sat_inc(entry_hist[idx]);
        end
        instr_hist[idx] = sat_inc(instr_hist[idx]);
        r.entries      = entry_hist[idx];
        r.instructions = instr_hist[idx];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 30) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        mismatches++;
    endtask

    task automatic queue_item(input logic op, input logic [FILE_ID_BITS-1:0] id,
                              input logic [LINE_BITS-1:0] ln);
        pending_items.push_back('{op: op, file_id: id, line: ln});
    endtask

    // driver: bursts of random length, random gaps in between
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_counts.push_back(profile_step(pending_items.pop_front()));
                if (burst_left > 0) begin
                    burst_left--;
                end
            end
            // a stalled transfer keeps its data and valid
            if (!(s_tvalid && !s_tready)) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left > 0 || pending_items.size() == 0) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_TDATA_BITS-FILE_ID_BITS-LINE_BITS){1'b0}},
                                 pending_items[0].line, pending_items[0].file_id};
                    s_tuser  <= pending_items[0].op;
                end
            end
        end
    end

    // monitor: checks each result transfer, ready follows a changing stall pattern
    always @(posedge aclk) begin
        line_counts_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_counts.size() == 0) begin
                    report_mismatch($sformatf("unexpected result tdata=%h tuser=%b",
                                              m_tdata, m_tuser));
                end else begin
                    want = expected_counts.pop_front();
                    if (m_tdata[OUT_BITS-1:0] !== want.entries ||
                        m_tdata[2*OUT_BITS-1:OUT_BITS] !== want.instructions ||
                        m_tuser[0] !== want.found || m_tuser[1] !== want.dropped) begin
                        report_mismatch($sformatf(
                            "entries %h/%h instructions %h/%h found %b/%b dropped %b/%b",
                            m_tdata[OUT_BITS-1:0], want.entries,
                            m_tdata[2*OUT_BITS-1:OUT_BITS], want.instructions,
                            m_tuser[0], want.found, m_tuser[1], want.dropped));
                    end
                end
            end
            ready_phase++;
            if (ready_phase % 64 == 0) begin
                ready_mode = $urandom_range(0, 3);
            end
            case (ready_mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= ($urandom_range(0, 1) == 1);
                end
                2: begin
                    m_tready <= (ready_phase % 4 == 0);
                end
                default: begin
                    m_tready <= ($urandom_range(0, 99) < 85);
                end
            endcase
        end
    end

    initial begin
        #3_200_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [FILE_ID_BITS-1:0] known_ids [MAX_FILES];
        logic [FILE_ID_BITS-1:0] id;
        logic [LINE_BITS-1:0]    hot [8];
        logic [LINE_BITS-1:0]    ln;
        int                      r;
        int                      cur;
        logic                    clash;

        files_used      = 0;
        cur_slot        = 0;
        cur_slot_known  = 1'b0;
        last_line       = '0;
        last_line_known = 1'b0;
        mismatches      = 0;
        burst_left      = 0;
        gap_left        = 0;
        ready_mode      = 0;
        ready_phase     = 0;
        for (int i = 0; i < MAX_FILES * MAX_LINES; i++) begin
            entry_hist[i] = '0;
            instr_hist[i] = '0;
        end

        known_ids[0] = 32'hFFFF_FFFF;
        known_ids[1] = 32'h0000_0001;
        known_ids[2] = 32'h8000_0000;
        known_ids[3] = 32'h5555_5555;
        known_ids[4] = 32'hAAAA_AAAA;
        for (int i = 5; i < MAX_FILES; i++) begin
            do begin
                id    = $urandom;
                clash = (id == '0) || (id == 32'hDEAD_BEEF);
                for (int j = 0; j < i; j++) begin
                    clash |= (known_ids[j] == id);
                end
            end while (clash);
            known_ids[i] = id;
        end
        hot[0] = '0;
        hot[1] = '1;
        for (int i = 2; i < 8; i++) begin
            hot[i] = 10'($urandom_range(0, 1023));
        end

        // directed: no file, unknown reads, repeats, line and file changes, table overflow
        queue_item(OP_COUNT, '0, 10'd5);
        queue_item(OP_READ, '0, '0);
        queue_item(OP_READ, known_ids[0], '0);
        queue_item(OP_COUNT, known_ids[0], '0);
        queue_item(OP_COUNT, known_ids[0], '0);
        queue_item(OP_COUNT, known_ids[0], '1);
        queue_item(OP_COUNT, known_ids[1], '1);
        queue_item(OP_COUNT, known_ids[0], '1);
        queue_item(OP_READ, known_ids[0], '1);
        queue_item(OP_READ, known_ids[0], '0);
        for (int i = 2; i < MAX_FILES; i++) begin
            queue_item(OP_COUNT, known_ids[i], hot[i]);
        end
        queue_item(OP_COUNT, 32'hDEAD_BEEF, 10'd7);
        queue_item(OP_COUNT, known_ids[MAX_FILES-1], hot[MAX_FILES-1]);
        queue_item(OP_READ, 32'hDEAD_BEEF, 10'd7);
        queue_item(OP_COUNT, '0, '1);
        queue_item(OP_READ, known_ids[1], '1);

        // random: mostly a trace walking known files and a few hot lines
        cur = MAX_FILES - 1;
        ln  = hot[cur];
        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                r = $urandom_range(0, 99);
                if (r >= 40) begin
                    ln = (r < 85) ? hot[$urandom_range(0, 7)] : 10'($urandom_range(0, 1023));
                end
                queue_item(OP_COUNT, known_ids[cur], ln);
            end else if (r < 72) begin
                cur = $urandom_range(0, MAX_FILES - 1);
                ln  = hot[$urandom_range(0, 7)];
                queue_item(OP_COUNT, known_ids[cur], ln);
            end else if (r < 87) begin
                queue_item(OP_READ, known_ids[$urandom_range(0, MAX_FILES - 1)],
                           ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                                       : hot[$urandom_range(0, 7)]);
            end else if (r < 92) begin
                queue_item(OP_COUNT, '0, 10'($urandom_range(0, 1023)));
            end else if (r < 96) begin
                queue_item(OP_COUNT, $urandom, 10'($urandom_range(0, 1023)));
            end else begin
                queue_item(OP_READ, ($urandom_range(0, 1) == 1) ? $urandom : '0,
                           10'($urandom_range(0, 1023)));
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (expected_counts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
src/slep_pkg.sv
src/slep_ram.sv
src/slep_front.sv
src/slep_queue.sv
src/slep_back.sv
src/source_line_execution_profiler.sv
tb/tb.sv
